>>> rtl/core/rse_pkg.sv
// Shared types and constants for the retransmission suppression block.
// No dependencies; every other file of the block uses this package.
package rse_pkg;

   localparam int SLOTS  = 256;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int TIME_W = 32;
   localparam int GF_W   = 16;
   localparam int PROD_W = TIME_W + GF_W;
   localparam int FRAC_W = 8;

   localparam logic [TIME_W-1:0] INITIAL_RST = TIME_W'(10);
   localparam logic [TIME_W-1:0] MAX_RST     = TIME_W'(250);
   localparam logic [GF_W-1:0]   GROWTH_RST  = GF_W'(512);

   typedef enum logic [1:0] {
      CMD_DECIDE_ENTRY    = 2'd0,
      CMD_DECIDE_UPSTREAM = 2'd1,
      CMD_GROW            = 2'd2,
      CMD_RELEASE         = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      DEC_NEW      = 2'd0,
      DEC_SUPPRESS = 2'd1,
      DEC_FORWARD  = 2'd2,
      DEC_DONE     = 2'd3
   } decision_type;

   typedef enum logic [1:0] {
      CSR_INITIAL = 2'd0,
      CSR_MAX     = 2'd1,
      CSR_GROWTH  = 2'd2
   } csr_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_LOOK   = 2'd1,
      ST_MUL    = 2'd2,
      ST_RESULT = 2'd3
   } state_type;

   typedef struct packed {
      logic              we;
      logic [SLOT_W-1:0] addr;
      logic [TIME_W-1:0] data;
   } ram_wr_type;

endpackage

>>> rtl/core/retx_suppression_exponential_top.sv
// Top level of the exponential retransmission suppression block.
// Uses rse_pkg, rse_ram (interval table) and rse_grow (growth unit).
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | cmd, slot, has_record, now_time, last_sent
//   rsp     | out       | rsp_valid/rsp_stall  | decision, interval_now
//   csr     | in        | csr_wr_en            | csr_index, csr_wdata
//
// One item at a time: each item is accepted, read from the table and presented as a
// result; an item whose interval grows passes the registered multiply step before the result.
// The registered table read and the single read-modify-write sequence per item keep items apart.
// Synchronous reset clears the slot valid bits and loads the CSRs with their defaults; no clearing pass.
// A stalled result waits in the output register; the next item may be accepted
// meanwhile and waits in the result state if the register is still full.
module retx_suppression_exponential_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_slot,
   input  logic        req_has_record,
   input  logic [31:0] req_now_time,
   input  logic [31:0] req_last_sent,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_decision,
   output logic [31:0] rsp_interval_now,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int SW = rse_pkg::SLOT_W;
   localparam int TW = rse_pkg::TIME_W;

   rse_pkg::state_type     state_ff, state_in;
   rse_pkg::cmd_type       cmd_ff;
   rse_pkg::decision_type  res_dec_ff, res_dec_in;
   logic [TW-1:0]          res_ival_ff, res_ival_in;
   logic [SW-1:0]          idx_ff;
   logic [SW-1:0]          req_idx;
   logic                   has_rec_ff;
   logic [TW-1:0]          elapsed_ff;
   logic                   valid_hit_ff;
   logic [rse_pkg::SLOTS-1:0] valid_ff, valid_in;

   logic [TW-1:0]               init_ff;
   logic [TW-1:0]               max_ff;
   logic [rse_pkg::GF_W-1:0]    gf_ff;

   logic                   rsp_valid_ff;
   rse_pkg::decision_type  rsp_dec_ff;
   logic [TW-1:0]          rsp_ival_ff;

   logic                   req_accept;
   logic                   out_load;
   logic                   grow_start;
   logic [TW-1:0]          rd_data;
   logic [TW-1:0]          cur;
   logic [TW-1:0]          grown;
   rse_pkg::ram_wr_type    ram_wr;

   assign req_idx    = req_slot[SW-1:0];
   assign req_stall  = (state_ff != rse_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // interval in force for this item: stored value, or the initial on first use
   assign cur = valid_hit_ff ? rd_data : init_ff;

   rse_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_en   (req_accept),
      .rd_addr (req_idx),
      .rd_data (rd_data)
   );

   rse_grow u_grow (
      .clock  (clock),
      .start  (grow_start),
      .base   (cur),
      .factor (gf_ff),
      .cap    (max_ff),
      .grown  (grown)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= rse_pkg::INITIAL_RST;
         max_ff  <= rse_pkg::MAX_RST;
         gf_ff   <= rse_pkg::GROWTH_RST;
      end else if (csr_wr_en) begin
         unique case (rse_pkg::csr_type'(csr_index))
            rse_pkg::CSR_INITIAL: init_ff <= csr_wdata;
            rse_pkg::CSR_MAX:     max_ff  <= csr_wdata;
            rse_pkg::CSR_GROWTH:  gf_ff   <= csr_wdata[rse_pkg::GF_W-1:0];
            default: ;
         endcase
      end
   end

   // item capture on transfer
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff       <= rse_pkg::cmd_type'(req_cmd);
         idx_ff       <= req_idx;
         has_rec_ff   <= req_has_record;
         elapsed_ff   <= req_now_time - req_last_sent;
         valid_hit_ff <= valid_ff[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rse_pkg::ST_IDLE;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_dec_ff  <= res_dec_in;
      res_ival_ff <= res_ival_in;
   end

   always_comb begin
      state_in    = state_ff;
      res_dec_in  = res_dec_ff;
      res_ival_in = res_ival_ff;
      valid_in    = valid_ff;
      grow_start  = 1'b0;
      out_load    = 1'b0;
      ram_wr      = '{we: 1'b0, addr: idx_ff, data: cur};

      unique case (state_ff)
         rse_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = rse_pkg::ST_LOOK;
            end
         end
         rse_pkg::ST_LOOK: begin
            state_in = rse_pkg::ST_RESULT;
            unique case (cmd_ff) inside
               rse_pkg::CMD_RELEASE: begin
                  valid_in[idx_ff] = 1'b0;
                  res_dec_in       = rse_pkg::DEC_DONE;
                  res_ival_in      = '0;
               end
               rse_pkg::CMD_GROW: begin
                  valid_in[idx_ff] = 1'b1;
                  grow_start       = 1'b1;
                  res_dec_in       = rse_pkg::DEC_DONE;
                  state_in         = rse_pkg::ST_MUL;
               end
               rse_pkg::CMD_DECIDE_ENTRY, rse_pkg::CMD_DECIDE_UPSTREAM: begin
                  if (!has_rec_ff) begin
                     res_dec_in  = rse_pkg::DEC_NEW;
                     res_ival_in = valid_hit_ff ? rd_data : '0;
                  end else begin
                     valid_in[idx_ff] = 1'b1;
                     ram_wr.we        = !valid_hit_ff;
                     res_ival_in      = cur;
                     if (elapsed_ff < cur) begin
                        res_dec_in = rse_pkg::DEC_SUPPRESS;
                     end else begin
                        res_dec_in = rse_pkg::DEC_FORWARD;
                        if (cmd_ff == rse_pkg::CMD_DECIDE_ENTRY) begin
                           grow_start = 1'b1;
                           state_in   = rse_pkg::ST_MUL;
                        end
                     end
                  end
               end
               default: ;
            endcase
         end
         rse_pkg::ST_MUL: begin
            ram_wr.we   = 1'b1;
            ram_wr.data = grown;
            res_ival_in = grown;
            state_in    = rse_pkg::ST_RESULT;
         end
         rse_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = rse_pkg::ST_IDLE;
            end
         end
         default: state_in = rse_pkg::ST_IDLE;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_dec_ff  <= res_dec_ff;
         rsp_ival_ff <= res_ival_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_decision     = rsp_dec_ff;
   assign rsp_interval_now = rsp_ival_ff;

`ifndef SYNTHESIS
   a_accept_to_look: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == rse_pkg::ST_LOOK))
      else $error("accepted item did not move to table lookup");

   a_mul_after_look: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rse_pkg::ST_MUL) |-> $past(state_ff == rse_pkg::ST_LOOK))
      else $error("growth cycle without a preceding lookup");

   a_grown_capped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rse_pkg::ST_MUL) |-> (grown <= max_ff))
      else $error("grown interval exceeds cap");

   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rse_pkg::ST_LOOK && cmd_ff == rse_pkg::CMD_RELEASE)
      |=> !valid_ff[idx_ff])
      else $error("released slot still valid");

   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == rse_pkg::ST_RESULT))
      else $error("result presented outside the result state");
`endif

endmodule

>>> rtl/core/rse_ram.sv
// Interval table: one write port, one read port, registered read data.
// Depends on rse_pkg.
module rse_ram (
   input  logic                          clock,
   input  rse_pkg::ram_wr_type           wr,
   input  logic                          rd_en,
   input  logic [rse_pkg::SLOT_W-1:0]    rd_addr,
   output logic [rse_pkg::TIME_W-1:0]    rd_data
);

   logic [rse_pkg::TIME_W-1:0] mem [rse_pkg::SLOTS];
   logic [rse_pkg::TIME_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/rse_grow.sv
// Interval growth: registered product with a Q8.8 factor, then truncate and cap.
// Depends on rse_pkg.
module rse_grow (
   input  logic                          clock,
   input  logic                          start,
   input  logic [rse_pkg::TIME_W-1:0]    base,
   input  logic [rse_pkg::GF_W-1:0]      factor,
   input  logic [rse_pkg::TIME_W-1:0]    cap,
   output logic [rse_pkg::TIME_W-1:0]    grown
);

   localparam int SHIFT_W = rse_pkg::PROD_W - rse_pkg::FRAC_W;

   logic [rse_pkg::PROD_W-1:0] prod_ff;
   logic [rse_pkg::PROD_W-1:0] prod_in;
   logic [SHIFT_W-1:0]         shifted;

   assign prod_in = rse_pkg::PROD_W'(base) * rse_pkg::PROD_W'(factor);

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= prod_in;
      end
   end

   // drop the fraction bits; compare at full width so overflow is caught
   assign shifted = prod_ff[rse_pkg::PROD_W-1:rse_pkg::FRAC_W];
   assign grown   = (shifted > SHIFT_W'(cap)) ? cap : shifted[rse_pkg::TIME_W-1:0];

endmodule

>>> verif/retx_suppression_exponential_top_tb.sv
// Self-checking testbench for retx_suppression_exponential_top.
// Depends on rse_pkg and the block's RTL. A built-in predictor of the
// per-slot suppression state checks every response transfer in order.
module retx_suppression_exponential_top_tb;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SCALED_W    = rse_pkg::PROD_W - rse_pkg::FRAC_W;

   typedef struct packed {
      rse_pkg::decision_type      dec;
      logic [rse_pkg::TIME_W-1:0] ivl;
   } verdict_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_cmd;
   logic [7:0]  req_slot;
   logic        req_has_record;
   logic [31:0] req_now_time;
   logic [31:0] req_last_sent;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_decision;
   logic [31:0] rsp_interval_now;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   // predictor state
   logic [rse_pkg::TIME_W-1:0] model_ivl [rse_pkg::SLOTS];
   logic                       model_live [rse_pkg::SLOTS];
   logic [rse_pkg::TIME_W-1:0] cfg_initial;
   logic [rse_pkg::TIME_W-1:0] cfg_max;
   logic [rse_pkg::GF_W-1:0]   cfg_growth;

   verdict_type pending_verdicts [$];
   int          error_count;
   int          cycle_count;
   int          hold_cycles;
   bit          rx_stall_on;
   bit          tx_gaps_on;
   bit          req_up;

   retx_suppression_exponential_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_slot         (req_slot),
      .req_has_record   (req_has_record),
      .req_now_time     (req_now_time),
      .req_last_sent    (req_last_sent),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_decision     (rsp_decision),
      .rsp_interval_now (rsp_interval_now),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   // Q8.8 multiply at full width, truncate, then cap
   function automatic logic [rse_pkg::TIME_W-1:0] grown(
         input logic [rse_pkg::TIME_W-1:0] ivl);
      logic [rse_pkg::PROD_W-1:0] prod;
      logic [SCALED_W-1:0]        scaled;
      prod   = rse_pkg::PROD_W'(ivl) * rse_pkg::PROD_W'(cfg_growth);
      scaled = prod[rse_pkg::PROD_W-1:rse_pkg::FRAC_W];
      if (scaled > SCALED_W'(cfg_max))
         return cfg_max;
      return scaled[rse_pkg::TIME_W-1:0];
   endfunction

   function automatic void open_slot(input logic [7:0] s);
      if (!model_live[s]) begin
         model_ivl[s]  = cfg_initial;
         model_live[s] = 1'b1;
      end
   endfunction

   function automatic verdict_type apply_request(input rse_pkg::cmd_type c,
                                                 input logic [7:0] s,
                                                 input logic hr,
                                                 input logic [31:0] nowv, lastv);
      verdict_type                r;
      logic [rse_pkg::TIME_W-1:0] span;
      span = nowv - lastv;
      case (c)
         rse_pkg::CMD_RELEASE: begin
            model_live[s] = 1'b0;
            model_ivl[s]  = '0;
            r.dec = rse_pkg::DEC_DONE;
         end
         rse_pkg::CMD_GROW: begin
            open_slot(s);
            model_ivl[s] = grown(model_ivl[s]);
            r.dec = rse_pkg::DEC_DONE;
         end
         default: begin
            if (!hr) begin
               r.dec = rse_pkg::DEC_NEW;
            end else begin
               open_slot(s);
               if (span < model_ivl[s]) begin
                  r.dec = rse_pkg::DEC_SUPPRESS;
               end else begin
                  if (c == rse_pkg::CMD_DECIDE_ENTRY)
                     model_ivl[s] = grown(model_ivl[s]);
                  r.dec = rse_pkg::DEC_FORWARD;
               end
            end
         end
      endcase
      r.ivl = model_live[s] ? model_ivl[s] : '0;
      return r;
   endfunction

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      verdict_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_verdicts.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response transfer: decision %0d interval %0d",
                        $time, rsp_decision, rsp_interval_now);
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_decision !== want.dec) begin
                  error_count++;
                  $display("%0t: decision mismatch: expected %s (%0d), actual %0d",
                           $time, want.dec.name(), want.dec, rsp_decision);
               end
               if (rsp_interval_now !== want.ivl) begin
                  error_count++;
                  $display("%0t: interval mismatch: expected %0d, actual %0d",
                           $time, want.ivl, rsp_interval_now);
               end
            end
         end
         if (req_valid && !req_stall)
            pending_verdicts.push_back(apply_request(rse_pkg::cmd_type'(req_cmd),
                                                     req_slot, req_has_record,
                                                     req_now_time, req_last_sent));
      end
   end

   // ---------------------------------------------------------------- receiver stalls

   initial begin : rx_stall_gen
      int len;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            len = hold_cycles;
            hold_cycles = 0;
            rsp_stall <= 1'b1;
            repeat (len) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!rx_stall_on) begin
            rsp_stall <= 1'b0;
         end else begin
            if ($urandom_range(0, 99) < 30) begin
               rsp_stall <= 1'b1;
               len = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40)
                                                  : $urandom_range(1, 3);
            end else begin
               rsp_stall <= 1'b0;
               len = $urandom_range(1, 8);
            end
            repeat (len - 1) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("retx_suppression_exponential_top_tb: errors");
      $finish;
   end

   // ---------------------------------------------------------------- sender

   function automatic int pick_gap();
      int r;
      if (!tx_gaps_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // called right after a rising edge; returns right after one
   task automatic send_req(input rse_pkg::cmd_type c, input logic [7:0] s,
                           input logic hr, input logic [31:0] nowv, lastv);
      int gap;
      req_valid      <= 1'b1;
      req_up          = 1'b1;
      req_cmd        <= c;
      req_slot       <= s;
      req_has_record <= hr;
      req_now_time   <= nowv;
      req_last_sent  <= lastv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_up     = 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // slots mostly from a small pool so state gets reused; elapsed time mostly near the interval
   task automatic send_random_req();
      rse_pkg::cmd_type           c;
      logic [7:0]                 s;
      logic                       hr;
      logic [rse_pkg::TIME_W-1:0] ivl, span, nowv;
      int                         pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)      c = rse_pkg::CMD_DECIDE_ENTRY;
      else if (pick < 70) c = rse_pkg::CMD_DECIDE_UPSTREAM;
      else if (pick < 88) c = rse_pkg::CMD_GROW;
      else                c = rse_pkg::CMD_RELEASE;
      s   = ($urandom_range(0, 99) < 75) ? 8'($urandom_range(0, 7)) : 8'($urandom());
      hr  = ($urandom_range(0, 99) < 85);
      ivl = model_live[s] ? model_ivl[s] : cfg_initial;
      case ($urandom_range(0, 6))
         0:       span = ivl - 1;
         1:       span = ivl;
         2:       span = ivl + 1;
         3:       span = $urandom_range(0, ivl);
         4:       span = $urandom();
         5:       span = '0;
         default: span = ivl + $urandom_range(0, ivl);
      endcase
      nowv = $urandom();
      send_req(c, s, hr, nowv, nowv - span);
   endtask

   // stop offering and wait for every outstanding response
   task automatic wait_idle();
      if (req_up) begin
         req_valid <= 1'b0;
         req_up     = 1'b0;
      end
      @(posedge clock);
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic apply_config(input logic [31:0] init_v, max_v, input logic [15:0] gr_v);
      csr_wr_en <= 1'b1;
      csr_index <= rse_pkg::CSR_INITIAL;
      csr_wdata <= init_v;
      @(posedge clock);
      csr_index <= rse_pkg::CSR_MAX;
      csr_wdata <= max_v;
      @(posedge clock);
      csr_index <= rse_pkg::CSR_GROWTH;
      csr_wdata <= {16'h0, gr_v};
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cfg_initial  = init_v;
      cfg_max      = max_v;
      cfg_growth   = gr_v;
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed();
      send_req(rse_pkg::CMD_DECIDE_ENTRY,    8'd0,   1'b0, 32'd0,   32'd0);
      send_req(rse_pkg::CMD_DECIDE_ENTRY,    8'd0,   1'b1, 32'd100, 32'd100);
      send_req(rse_pkg::CMD_DECIDE_ENTRY,    8'd0,   1'b1, 32'd109, 32'd100);
      send_req(rse_pkg::CMD_DECIDE_ENTRY,    8'd0,   1'b1, 32'd110, 32'd100);
      send_req(rse_pkg::CMD_DECIDE_UPSTREAM, 8'd1,   1'b1, 32'd1000, 32'd0);
      send_req(rse_pkg::CMD_DECIDE_UPSTREAM, 8'd1,   1'b0, 32'd5,   32'd0);
      send_req(rse_pkg::CMD_GROW,            8'd1,   1'b0, $urandom(), $urandom());
      // grow on an unused slot, then up to and past the cap
      send_req(rse_pkg::CMD_GROW,            8'd2,   1'b1, $urandom(), $urandom());
      repeat (5) send_req(rse_pkg::CMD_GROW, 8'd2,   1'b0, 32'd0,   32'd0);
      send_req(rse_pkg::CMD_RELEASE,         8'd2,   1'b1, $urandom(), $urandom());
      send_req(rse_pkg::CMD_RELEASE,         8'd3,   1'b0, 32'd0,   32'd0);
      send_req(rse_pkg::CMD_DECIDE_ENTRY,    8'd2,   1'b1, 32'd7,   32'd7);
      // time going backwards wraps
      send_req(rse_pkg::CMD_DECIDE_UPSTREAM, 8'd0,   1'b1, 32'd5,   32'hFFFF_FFFE);
      send_req(rse_pkg::CMD_DECIDE_UPSTREAM, 8'd0,   1'b1, 32'd0,   32'd1);
      send_req(rse_pkg::CMD_DECIDE_ENTRY,    8'd255, 1'b1, 32'hFFFF_FFFF, 32'd0);
      send_req(rse_pkg::CMD_DECIDE_ENTRY,    8'd170, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_req(rse_pkg::CMD_DECIDE_ENTRY,    8'd85,  1'b1, 32'h5555_5555, 32'hAAAA_AAAA);
      wait_idle();
   endtask

   // receiver holds off while the sender keeps offering back to back
   task automatic test_backpressure();
      tx_gaps_on  = 1'b0;
      hold_cycles = 300;
      repeat (40) send_random_req();
      tx_gaps_on  = 1'b1;
      wait_idle();
   endtask

   task automatic test_random_defaults();
      rx_stall_on = 1'b0;
      tx_gaps_on  = 1'b0;
      repeat (100) send_random_req();
      rx_stall_on = 1'b1;
      tx_gaps_on  = 1'b1;
      repeat (200) send_random_req();
      wait_idle();
   endtask

   task automatic test_config_extremes();
      apply_config(32'd1, 32'hFFFF_FFFF, 16'hFFFF);
      repeat (120) send_random_req();
      wait_idle();
      // cap below the initial interval only bites at the first growth
      apply_config(32'hFFFF_FFFF, 32'd1, 16'd256);
      repeat (120) send_random_req();
      wait_idle();
      apply_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      repeat (120) send_random_req();
      wait_idle();
   endtask

   task automatic test_config_random();
      logic [31:0] init_v, max_v;
      logic [15:0] gr_v;
      repeat (5) begin
         if ($urandom_range(0, 1)) init_v = $urandom_range(1, 64);
         else                      init_v = $urandom() | 32'h1;
         if ($urandom_range(0, 3) == 0) begin
            max_v = $urandom() | 32'h1;
         end else begin
            max_v = init_v + $urandom_range(0, 5000);
            if (max_v < init_v) max_v = 32'hFFFF_FFFF;
         end
         gr_v = $urandom_range(0, 1) ? $urandom_range(256, 1024) : $urandom_range(256, 65535);
         apply_config(init_v, max_v, gr_v);
         repeat (150) send_random_req();
         wait_idle();
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = rse_pkg::CMD_DECIDE_ENTRY;
      req_slot       = '0;
      req_has_record = 1'b0;
      req_now_time   = '0;
      req_last_sent  = '0;
      csr_wr_en      = 1'b0;
      csr_index      = rse_pkg::CSR_INITIAL;
      csr_wdata      = '0;
      req_up         = 1'b0;
      rx_stall_on    = 1'b1;
      tx_gaps_on     = 1'b1;
      hold_cycles    = 0;
      error_count    = 0;
      cfg_initial    = rse_pkg::INITIAL_RST;
      cfg_max        = rse_pkg::MAX_RST;
      cfg_growth     = rse_pkg::GROWTH_RST;
      for (int i = 0; i < rse_pkg::SLOTS; i++) begin
         model_ivl[i]  = '0;
         model_live[i] = 1'b0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_backpressure();
      test_random_defaults();
      test_config_extremes();
      test_config_random();

      wait_idle();
      repeat (8) @(posedge clock);
      if (pending_verdicts.size() != 0)
         error_count++;
      if (error_count == 0)
         $display("retx_suppression_exponential_top_tb: clean");
      else
         $display("retx_suppression_exponential_top_tb: errors");
      $finish;
   end

endmodule
